@@ design/wamm_pkg.sv @@
package wamm_pkg;

  localparam int SampleW = 16;
  localparam logic [SampleW-1:0] SampleMax = 16'hffff;

  // controller to datapath
  typedef struct packed {
    logic load;      // take the new sample, reset the accumulators
    logic read;      // issue one ring read and step the scan index
    logic mul;       // multiply the sum by the reciprocal of the window
    logic out_load;  // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;  // scan index is on the last ring entry
    logic out_busy;  // output register holds a transaction not yet taken
  } status_t;

endpackage

@@ design/window_average_min_max_unit.sv @@
// Moving average with window minimum and maximum. Every input transaction
// carries one unsigned 16-bit sample, which is written into a ring of WINDOW
// entries at a wrapping write position; the unit then returns one output
// transaction with the truncated mean, the largest and the smallest of all
// WINDOW entries. The ring reads as all zeros after reset, so until WINDOW
// samples have gone in, the unwritten entries count as zeros (smallest stays
// 0 and the mean is pulled down). From acceptance to a loaded result, each
// sample goes through these steps: write the ring, scan it through its single
// read port, let the last read reach the accumulators, form the mean with a
// reciprocal multiply, and load the output register. The output register
// lets the next sample be accepted while a result still waits to be taken;
// a result is only blocked from loading while the previous one sits
// stalled.
module window_average_min_max_unit #(
  parameter int WINDOW = 8  // ring depth, 2 to 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wamm_pkg::SampleW-1:0] sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wamm_pkg::SampleW-1:0] mean,
  output logic [wamm_pkg::SampleW-1:0] largest,
  output logic [wamm_pkg::SampleW-1:0] smallest
);
  import wamm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing: accept, scan, multiply, hand off
  wamm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // ring, accumulators, reciprocal multiply and output register
  wamm_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mean      (mean),
    .largest   (largest),
    .smallest  (smallest)
  );

endmodule

@@ design/wamm_ctrl.sv @@
module wamm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  wamm_pkg::status_t status,
  output wamm_pkg::cmd_t    cmd
);
  import wamm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.read = 1'b1;
        if (status.idx_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last read word lands in the accumulators
      ST_DRAIN: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/wamm_datapath.sv @@
module wamm_datapath #(
  parameter int WINDOW = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  wamm_pkg::cmd_t                 cmd,
  output wamm_pkg::status_t              status,
  input  logic [wamm_pkg::SampleW-1:0]   sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wamm_pkg::SampleW-1:0]   mean,
  output logic [wamm_pkg::SampleW-1:0]   largest,
  output logic [wamm_pkg::SampleW-1:0]   smallest
);
  import wamm_pkg::*;

  localparam int IdxW   = $clog2(WINDOW);
  localparam int SumW   = SampleW + IdxW;
  localparam int RecipW = SumW + 1;
  localparam int Shift  = SumW + IdxW;
  localparam int ProdW  = SumW + RecipW;
  // ceil(2^Shift / WINDOW): exact floor division for any SumW-bit sum
  localparam logic [63:0] Recip64 = ((64'd1 << Shift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RecipW-1:0] Recip = RecipW'(Recip64);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(WINDOW - 1);

  logic [SampleW-1:0] ring [WINDOW];
  logic [WINDOW-1:0]  ring_vld;
  logic [IdxW-1:0]    pos;
  logic [IdxW-1:0]    idx;
  logic [SampleW-1:0] rd_data;
  logic               rd_ok;
  logic               rd_live;
  logic [SampleW-1:0] entry;
  logic [SumW-1:0]    sum;
  logic [SampleW-1:0] hi;
  logic [SampleW-1:0] lo;
  logic [ProdW-1:0]   prod;

  assign status.idx_last = (idx == IdxLast);
  assign status.out_busy = out_valid && out_stall;

  // ring storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring[pos] <= sample;
    end
    rd_data <= ring[idx];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      pos      <= '0;
      idx      <= '0;
      rd_live  <= 1'b0;
      rd_ok    <= 1'b0;
    end else begin
      rd_live <= cmd.read;
      rd_ok   <= ring_vld[idx];
      if (cmd.load) begin
        ring_vld[pos] <= 1'b1;
        pos           <= (pos == IdxLast) ? '0 : pos + 1'b1;
        idx           <= '0;
      end else if (cmd.read) begin
        idx <= (idx == IdxLast) ? '0 : idx + 1'b1;
      end
    end
  end

  assign entry = rd_ok ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum <= '0;
      hi  <= '0;
      lo  <= SampleMax;
    end else if (rd_live) begin
      sum <= sum + SumW'(entry);
      if (entry > hi) begin
        hi <= entry;
      end
      if (entry < lo) begin
        lo <= entry;
      end
    end
    if (cmd.mul) begin
      prod <= ProdW'(sum) * ProdW'(Recip);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean     <= prod[Shift +: SampleW];
      largest  <= hi;
      smallest <= lo;
    end
  end

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wamm_pkg::*;

  // ring depth of the unit under test
  localparam int WindowLen = 8;
  // scan latency plus some slack, used after the last result
  localparam int SettleCycles = WindowLen + 8;

  typedef logic [SampleW-1:0] sample_t;

  // one output transaction: the statistics of the whole ring
  typedef struct packed {
    sample_t mean;
    sample_t largest;
    sample_t smallest;
  } window_stats_t;

  // shapes of random sample runs
  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_HIGH,
    SHAPE_LOW,
    SHAPE_HOLD,
    SHAPE_ONE_HOT
  } sample_shape_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t sample = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t mean;
  sample_t largest;
  sample_t smallest;

  // shadow copy of the ring and its write pointer
  sample_t ring_shadow [WindowLen];
  int      ring_wr_pos = 0;

  // statistics still owed by the unit, oldest first
  window_stats_t expected_stats [$];

  int sent_count = 0;
  int checked_count = 0;
  int flat_windows = 0;
  int error_count = 0;

  // idling controls for each side
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int stall_left = 0;

  // random sample shaping
  sample_shape_t shape = SHAPE_RANDOM;
  int      shape_left = 0;
  sample_t last_sample = '0;

  window_average_min_max_unit #(
    .WINDOW(WindowLen)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mean     (mean),
    .largest  (largest),
    .smallest (smallest)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // write one sample into the shadow ring, then scan all entries
  function automatic window_stats_t compute_window_stats(input sample_t value);
    window_stats_t stats;
    int unsigned   total;
    ring_shadow[ring_wr_pos] = value;
    ring_wr_pos = (ring_wr_pos == WindowLen - 1) ? 0 : ring_wr_pos + 1;
    total = 0;
    stats.largest = '0;
    stats.smallest = SampleMax;
    foreach (ring_shadow[k]) begin
      total += ring_shadow[k];
      if (ring_shadow[k] > stats.largest) stats.largest = ring_shadow[k];
      if (ring_shadow[k] < stats.smallest) stats.smallest = ring_shadow[k];
    end
    // truncating divide, sum of the ring always fits well within 32 bits
    stats.mean = sample_t'(total / WindowLen);
    return stats;
  endfunction

  // random samples come in runs of one shape, so plateaus and edges show up
  function automatic sample_t next_sample();
    sample_t value;
    if (shape_left == 0) begin
      shape = sample_shape_t'($urandom_range(SHAPE_RANDOM, SHAPE_ONE_HOT));
      shape_left = $urandom_range(1, 12);
    end
    shape_left--;
    case (shape)
      SHAPE_HIGH:    value = SampleMax - sample_t'($urandom_range(0, 15));
      SHAPE_LOW:     value = sample_t'($urandom_range(0, 15));
      SHAPE_HOLD:    value = last_sample;
      SHAPE_ONE_HOT: value = sample_t'(1) << $urandom_range(0, SampleW - 1);
      default:       value = sample_t'($urandom_range(0, 65535));
    endcase
    last_sample = value;
    return value;
  endfunction

  // drive one input transaction, predict its result once it is taken
  task automatic send_sample(input sample_t value);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    sample = value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_stats.push_back(compute_window_stats(value));
    sent_count++;
  endtask

  // stop sending and wait until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic void compare_field(input string name, input sample_t want,
                                        input sample_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // output stalls come in random bursts while enabled
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(1, 11) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // every output transaction is matched against the oldest prediction
  always @(posedge clk) begin
    window_stats_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result, mean %h largest %h smallest %h",
                 $time, mean, largest, smallest);
        error_count++;
      end else begin
        want = expected_stats.pop_front();
        compare_field("mean", want.mean, mean);
        compare_field("largest", want.largest, largest);
        compare_field("smallest", want.smallest, smallest);
        if (want.largest == want.smallest) flat_windows++;
        checked_count++;
      end
    end
  end

  // ring still partly cleared: zeros hold smallest down and drag the mean
  task automatic test_window_fill();
    sample_t fill_values [WindowLen] = '{16'hffff, 16'h0000, 16'h0001, 16'hfffe,
                                         16'h8000, 16'h7fff, 16'haaaa, 16'h5555};
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    foreach (fill_values[k]) send_sample(fill_values[k]);
  endtask

  // full-scale window, then zeros wrapping over it, under idling on both sides
  task automatic test_constant_window();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (WindowLen) send_sample(SampleMax);
    repeat (6) send_sample('0);
    // hold off until everything is back before going random
    drain_results();
  endtask

  // shaped random samples, idling switched per block so there are quiet stretches
  task automatic test_random_traffic();
    for (int blk = 0; blk < 12; blk++) begin
      gaps_on = (blk % 3 != 2);
      stalls_on = (blk % 4 != 1);
      repeat (100) send_sample(next_sample());
      if (blk == 5) drain_results();
    end
  endtask

  // closing stretch at full rate, no gaps and no stalls
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (380) send_sample(next_sample());
  endtask

  initial begin
    foreach (ring_shadow[k]) ring_shadow[k] = '0;
    // synchronous reset held, then released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_window_fill();
    test_constant_window();
    test_random_traffic();
    test_back_to_back();

    drain_results();
    $display("%0d samples sent, %0d window results checked, %0d of them flat",
             sent_count, checked_count, flat_windows);
    $display("covered ring fill from reset, wrap, full-scale and shaped random data");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
